/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/scdm_pkg.sv */
// types and constants for the sparse csc by dense matrix multiplier
// no dependencies
package scdm_pkg;

   localparam int MAX_DIM     = 16;
   localparam int IDX_W       = $clog2(MAX_DIM);
   localparam int ADDR_W      = 2 * IDX_W;
   localparam int DEPTH       = MAX_DIM * MAX_DIM;
   localparam int DATA_W      = 32;
   localparam int COLS_W      = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [COLS_W-1:0] DENSE_COLS_RESET = COLS_W'(MAX_DIM);
   localparam logic [COLS_W-1:0] COLS_MAX         = COLS_W'(MAX_DIM);
   localparam int                REG_DENSE_COLS   = 0;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_APPLY = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [IDX_W-1:0]          row;
      logic [IDX_W-1:0]          col;
      logic signed [DATA_W-1:0]  value;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MAC,
      BK_DRAIN
   } back_state_type;

endpackage

/* hw/rtl/scdm_front.sv */
// front end: takes request transfers, decodes the action and queues commands
// depends on scdm_pkg and assert_macros.svh
`include "assert_macros.svh"

module scdm_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_action,
   input  logic [scdm_pkg::IDX_W-1:0]     req_row_index,
   input  logic [scdm_pkg::IDX_W-1:0]     req_col_index,
   input  logic signed [scdm_pkg::DATA_W-1:0] req_value,
   output logic                           cmd_valid,
   output scdm_pkg::cmd_type              cmd,
   input  logic                           cmd_pop
);
   import scdm_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                push;
   logic                pop;
   cmd_type             new_cmd;

   always_comb begin
      new_cmd.op    = op_type'(req_action);
      new_cmd.row   = req_row_index;
      new_cmd.col   = req_col_index;
      new_cmd.value = req_value;
   end

   assign busy      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign push      = start && !busy;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   `ASSERT_IMP(a_queue_bound, clock, reset, 1'b1, count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
   `ASSERT_NXT(a_pop_drains, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1)
   `ASSERT_NXT(a_push_fills, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

/* hw/rtl/scdm_back.sv */
// back end: dense store, result store and the multiply-accumulate pipeline
// depends on scdm_pkg and assert_macros.svh
`include "assert_macros.svh"

module scdm_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_valid,
   input  scdm_pkg::cmd_type                  cmd,
   output logic                               cmd_pop,
   input  logic [scdm_pkg::COLS_W-1:0]        dense_cols,
   output logic                               rsp_valid,
   output logic signed [scdm_pkg::DATA_W-1:0] rsp_read_value
);
   import scdm_pkg::*;

   back_state_type      state_ff, state_in;

   logic [DATA_W-1:0]   dense_mem [DEPTH];
   logic [DATA_W-1:0]   res_mem   [DEPTH];
   logic [DEPTH-1:0]    res_valid_ff;

   logic [IDX_W-1:0]    row_ff, col_ff;
   logic [DATA_W-1:0]   value_ff;
   logic [COLS_W-1:0]   ncols_ff;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;

   logic [COLS_W-1:0]   ncols_clamp;
   logic                k_last;
   logic                dense_we;
   logic                clear_all;
   logic                start_apply;
   logic                issue_read;
   logic                issue_mac;
   logic [ADDR_W-1:0]   res_rd_addr;

   logic                s1_valid_ff, s1_read_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic [DATA_W-1:0]   dense_q_ff;
   logic [DATA_W-1:0]   res_q_ff;
   logic                res_vq_ff;

   logic                s2_valid_ff;
   logic [ADDR_W-1:0]   s2_addr_ff;
   logic [DATA_W-1:0]   prod_ff, prod_in;
   logic [DATA_W-1:0]   addend_ff;
   logic [DATA_W-1:0]   sum;

   assign ncols_clamp = (dense_cols > COLS_MAX) ? COLS_MAX : dense_cols;
   assign k_last      = ((COLS_W'(cnt_ff) + COLS_W'(1)) == ncols_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && cmd.op == OP_APPLY && ncols_clamp != '0) begin
               state_in = BK_MAC;
            end else if (cmd_valid && cmd.op == OP_READ) begin
               state_in = BK_DRAIN;
            end
         end
         BK_MAC: begin
            if (k_last) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop     = 1'b0;
      dense_we    = 1'b0;
      clear_all   = 1'b0;
      start_apply = 1'b0;
      issue_read  = 1'b0;
      issue_mac   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            cmd_pop     = cmd_valid;
            dense_we    = cmd_valid && cmd.op == OP_LOAD;
            clear_all   = cmd_valid && cmd.op == OP_CLEAR;
            start_apply = cmd_valid && cmd.op == OP_APPLY && ncols_clamp != '0;
            issue_read  = cmd_valid && cmd.op == OP_READ;
         end
         BK_MAC: begin
            issue_mac = 1'b1;
         end
         BK_DRAIN: begin
         end
         default: begin
         end
      endcase
   end

   assign res_rd_addr = issue_mac ? {row_ff, cnt_ff} : {cmd.row, cmd.col};

   always_comb begin
      cnt_in = cnt_ff;
      if (start_apply) begin
         cnt_in = '0;
      end else if (issue_mac) begin
         cnt_in = cnt_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s1_read_ff  <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         s1_valid_ff <= issue_mac || issue_read;
         s1_read_ff  <= issue_read;
         s2_valid_ff <= s1_valid_ff && !s1_read_ff;
      end
   end

   // apply operands held for the whole column sweep
   always_ff @(posedge clock) begin
      if (start_apply) begin
         row_ff   <= cmd.row;
         col_ff   <= cmd.col;
         value_ff <= cmd.value;
         ncols_ff <= ncols_clamp;
      end
   end

   // dense store
   always_ff @(posedge clock) begin
      if (dense_we) begin
         dense_mem[{cmd.row, cmd.col}] <= cmd.value;
      end
      dense_q_ff <= dense_mem[{col_ff, cnt_ff}];
   end

   // result store, entries without a valid bit read as zero
   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         res_mem[s2_addr_ff] <= sum;
      end
      res_q_ff <= res_mem[res_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         res_valid_ff <= '0;
      end else if (s2_valid_ff) begin
         res_valid_ff[s2_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      res_vq_ff  <= res_valid_ff[res_rd_addr];
      s1_addr_ff <= res_rd_addr;
   end

   // multiply stage, low word of the product
   assign prod_in = value_ff * dense_q_ff;

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      addend_ff  <= res_vq_ff ? res_q_ff : '0;
      s2_addr_ff <= s1_addr_ff;
   end

   assign sum = prod_ff + addend_ff;

   assign rsp_valid      = s1_valid_ff && s1_read_ff;
   assign rsp_read_value = res_vq_ff ? $signed(res_q_ff) : '0;

   `ASSERT_IMP(a_read_after_drain, clock, reset, rsp_valid, !s2_valid_ff)
   `ASSERT_IMP(a_pop_when_empty_pipe, clock, reset, cmd_pop, !s1_valid_ff && !s2_valid_ff)
   `ASSERT_NXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)

endmodule

/* hw/rtl/sparse_csc_dense_matmul.sv */
// top level of the sparse csc by dense matrix multiplier with its csr port
// depends on scdm_pkg, scdm_front and scdm_back
//
//   channel   direction  handshake             fields
//   request   in         start / busy          req_action, req_row_index, req_col_index, req_value
//   response  out        rsp_valid strobe      rsp_read_value
//   csr       in/out     psel/penable/pready   paddr, pwdata, prdata (dense_cols at 0)
//
// an apply runs min(dense_cols,16) multiply-accumulates in the back end, one
// per column through the single multiplier and result memory port
// the response strobe comes in the cycle after dispatch
// busy rises when the two-entry command queue is full
// reset clears the queue, the pipeline and the result valid bits
module sparse_csc_dense_matmul (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_action,
   input  logic [scdm_pkg::IDX_W-1:0]             req_row_index,
   input  logic [scdm_pkg::IDX_W-1:0]             req_col_index,
   input  logic signed [scdm_pkg::DATA_W-1:0]     req_value,
   output logic                                   rsp_valid,
   output logic signed [scdm_pkg::DATA_W-1:0]     rsp_read_value,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [scdm_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [scdm_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [scdm_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready
);
   import scdm_pkg::*;

   logic [COLS_W-1:0] dense_cols_ff, dense_cols_in;
   logic              csr_write;
   logic              csr_hit;
   logic              cmd_valid;
   logic              cmd_pop;
   cmd_type           cmd;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_hit   = (paddr == CSR_ADDR_W'(4 * REG_DENSE_COLS));

   always_comb begin
      dense_cols_in = dense_cols_ff;
      if (csr_write && csr_hit) begin
         dense_cols_in = pwdata[COLS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dense_cols_ff <= DENSE_COLS_RESET;
      end else begin
         dense_cols_ff <= dense_cols_in;
      end
   end

   assign prdata = csr_hit ? CSR_DATA_W'(dense_cols_ff) : '0;

   scdm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_value     (req_value),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   scdm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop),
      .dense_cols     (dense_cols_ff),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value)
   );

endmodule

/* tb/sv/sparse_csc_dense_matmul_test.sv */
// self-checking testbench for the sparse csc by dense matrix multiplier
// runs a directed table then random phases over several dense_cols settings
// depends on scdm_pkg and sparse_csc_dense_matmul
module sparse_csc_dense_matmul_test;
   import scdm_pkg::*;

   localparam int GAP_MAX       = 16;
   localparam int SETTLE_CYCLES = 64;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 240;
   localparam int DIRECTED_N    = 27;

   typedef struct packed {
      op_type              op;
      logic [IDX_W-1:0]    row;
      logic [IDX_W-1:0]    col;
      logic [DATA_W-1:0]   value;
      logic                typed;
      logic [DATA_W-1:0]   read_value;
   } matmul_step_type;

   localparam matmul_step_type DIRECTED [DIRECTED_N] = '{
      '{OP_READ,  4'd0,  4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_READ,  4'd15, 4'd15, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_LOAD,  4'd15, 4'd0,  32'h7fff_ffff, 1'b0, 32'h0000_0000},
      '{OP_LOAD,  4'd15, 4'd1,  32'h8000_0000, 1'b0, 32'h0000_0000},
      '{OP_LOAD,  4'd15, 4'd2,  32'hffff_ffff, 1'b0, 32'h0000_0000},
      '{OP_LOAD,  4'd15, 4'd3,  32'h0000_0001, 1'b0, 32'h0000_0000},
      '{OP_LOAD,  4'd15, 4'd4,  32'h0000_0000, 1'b0, 32'h0000_0000},
      '{OP_LOAD,  4'd15, 4'd5,  32'h0000_0002, 1'b0, 32'h0000_0000},
      '{OP_LOAD,  4'd15, 4'd6,  32'hffff_fffe, 1'b0, 32'h0000_0000},
      '{OP_LOAD,  4'd15, 4'd7,  32'h1234_5678, 1'b0, 32'h0000_0000},
      '{OP_LOAD,  4'd15, 4'd8,  32'h0000_ffff, 1'b0, 32'h0000_0000},
      '{OP_LOAD,  4'd15, 4'd9,  32'hffff_0000, 1'b0, 32'h0000_0000},
      '{OP_LOAD,  4'd15, 4'd10, 32'h5555_5555, 1'b0, 32'h0000_0000},
      '{OP_LOAD,  4'd15, 4'd11, 32'haaaa_aaaa, 1'b0, 32'h0000_0000},
      '{OP_LOAD,  4'd15, 4'd12, 32'h0000_0003, 1'b0, 32'h0000_0000},
      '{OP_LOAD,  4'd15, 4'd13, 32'h7fff_fffe, 1'b0, 32'h0000_0000},
      '{OP_LOAD,  4'd15, 4'd14, 32'h8000_0001, 1'b0, 32'h0000_0000},
      '{OP_LOAD,  4'd15, 4'd15, 32'h0000_0010, 1'b0, 32'h0000_0000},
      '{OP_APPLY, 4'd15, 4'd15, 32'h7fff_ffff, 1'b0, 32'h0000_0000},
      '{OP_APPLY, 4'd0,  4'd15, 32'h8000_0000, 1'b0, 32'h0000_0000},
      '{OP_APPLY, 4'd0,  4'd15, 32'hffff_ffff, 1'b0, 32'h0000_0000},
      '{OP_READ,  4'd15, 4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000},
      '{OP_READ,  4'd0,  4'd1,  32'h0000_0000, 1'b0, 32'h0000_0000},
      '{OP_READ,  4'd15, 4'd15, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{OP_CLEAR, 4'd0,  4'd0,  32'h0000_0000, 1'b0, 32'h0000_0000},
      '{OP_READ,  4'd15, 4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_READ,  4'd0,  4'd15, 32'h0000_0000, 1'b1, 32'h0000_0000}
   };

   localparam logic [COLS_W-1:0] PHASE_COLS [PHASES] = '{
      5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd7, 5'd16, 5'd3
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [1:0]                 req_action = '0;
   logic [IDX_W-1:0]           req_row_index = '0;
   logic [IDX_W-1:0]           req_col_index = '0;
   logic signed [DATA_W-1:0]   req_value = '0;
   logic                       rsp_valid;
   logic signed [DATA_W-1:0]   rsp_read_value;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]      paddr = '0;
   logic [CSR_DATA_W-1:0]      pwdata = '0;
   logic [CSR_DATA_W-1:0]      prdata;
   logic                       pready;

   logic [DATA_W-1:0]          dense_copy [DEPTH];
   logic [DATA_W-1:0]          result_copy [DEPTH];
   bit                         dense_loaded [DEPTH];
   logic [COLS_W-1:0]          cols_copy = DENSE_COLS_RESET;
   logic [DATA_W-1:0]          expected_reads [$];
   logic [DATA_W-1:0]          oldest_read;
   bit                         sender_no_gap = 1'b0;
   int                         errors = 0;
   int                         stall_cycles = 0;

   sparse_csc_dense_matmul u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_row_index  (req_row_index),
      .req_col_index  (req_col_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int active_cols();
      return (cols_copy > COLS_MAX) ? MAX_DIM : int'(cols_copy);
   endfunction

   function automatic logic [DATA_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2, 3: return DATA_W'(int'($urandom_range(0, 16)) - 8);
         default: return $urandom;
      endcase
   endfunction

   // update the copy of the stores for one accepted command
   task automatic update_products(input op_type op, input logic [IDX_W-1:0] row,
                                  input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value,
                                  output bit has_read, output logic [DATA_W-1:0] read_value);
      int n;
      n = active_cols();
      has_read = 1'b0;
      read_value = '0;
      case (op)
         OP_LOAD: begin
            dense_copy[row * MAX_DIM + col] = value;
            dense_loaded[row * MAX_DIM + col] = 1'b1;
         end
         OP_APPLY: begin
            for (int k = 0; k < n; k++)
               result_copy[row * MAX_DIM + k] += value * dense_copy[col * MAX_DIM + k];
         end
         OP_READ: begin
            has_read = 1'b1;
            read_value = result_copy[row * MAX_DIM + col];
         end
         default: begin
            for (int i = 0; i < DEPTH; i++)
               result_copy[i] = '0;
         end
      endcase
   endtask

   task automatic send_command(input op_type op, input logic [IDX_W-1:0] row,
                               input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value,
                               input bit typed, input logic [DATA_W-1:0] typed_read);
      int gap;
      bit has_read;
      logic [DATA_W-1:0] predicted;
      gap = sender_no_gap ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_action <= op;
      req_row_index <= row;
      req_col_index <= col;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      update_products(op, row, col, value, has_read, predicted);
      if (has_read)
         expected_reads.push_back(typed ? typed_read : predicted);
   endtask

   // applies only touch dense rows that are fully loaded over the active columns
   task automatic send_random_command();
      op_type op;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      int pick;
      int n;
      int k;
      pick = $urandom_range(0, 99);
      row = IDX_W'($urandom);
      col = IDX_W'($urandom);
      n = active_cols();
      if (pick < 25)
         op = OP_LOAD;
      else if (pick < 65)
         op = OP_APPLY;
      else if (pick < 97)
         op = OP_READ;
      else
         op = OP_CLEAR;
      if (op == OP_APPLY) begin
         for (k = 0; k < n && dense_loaded[col * MAX_DIM + k]; k++);
         if (k < n) begin
            op = OP_LOAD;
            row = col;
            col = IDX_W'(k);
         end
      end
      send_command(op, row, col, random_value(), 1'b0, '0);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (expected_reads.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // upper data bits are random, only the low field is kept
   task automatic write_dense_cols(input logic [COLS_W-1:0] cols);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(4 * REG_DENSE_COLS);
      pwdata <= ($urandom & ~32'h1f) | CSR_DATA_W'(cols);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      cols_copy = cols;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_reads.size() == 0) begin
            $error("read_value: unexpected transfer, actual %h", rsp_read_value);
            errors++;
         end else begin
            oldest_read = expected_reads.pop_front();
            if (rsp_read_value !== oldest_read) begin
               $error("read_value: expected %h, actual %h", oldest_read, rsp_read_value);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [COLS_W-1:0] cols;
      for (int i = 0; i < DEPTH; i++) begin
         result_copy[i] = '0;
         dense_copy[i] = '0;
         dense_loaded[i] = 1'b0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_N; i++)
         send_command(DIRECTED[i].op, DIRECTED[i].row, DIRECTED[i].col,
                      DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].read_value);
      wait_idle();
      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            wait_idle();
            cols = (p == PHASES - 1) ? COLS_W'($urandom_range(1, MAX_DIM)) : PHASE_COLS[p];
            write_dense_cols(cols);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 63) == 0)
               sender_no_gap = !sender_no_gap;
            send_random_command();
         end
      end
      wait_idle();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/scdm_pkg.sv
hw/rtl/scdm_front.sv
hw/rtl/scdm_back.sv
hw/rtl/sparse_csc_dense_matmul.sv
tb/sv/sparse_csc_dense_matmul_test.sv
